// ===== hdl/wfsc_pkg.sv =====
// Package for the word frequency sorted counter.
// Holds operation and status codes, table sizes and the sequencer state type.
// No dependencies.
package wfsc_pkg;

    localparam int MaxWords   = 1024;
    localparam int WordBuffer = 20;
    localparam int MaxChars   = WordBuffer - 1;
    localparam int AddrW      = $clog2(MaxWords);
    localparam int CountW     = $clog2(MaxWords + 1);
    localparam int WordW      = 152;

    typedef enum logic [1:0] {
        OP_TEXT = 2'd0,
        OP_END  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_WORD  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_TOTAL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CMP,
        S_CNT_RD,
        S_CNT_CMP,
        S_DONE
    } state_t;

    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChComma = 8'h2C;
    localparam logic [7:0] ChDot   = 8'h2E;
    localparam logic [7:0] ChBang  = 8'h21;
    localparam logic [7:0] ChQuery = 8'h3F;

    // Compare word a against b as byte strings; byte 0 is most significant.
    function automatic logic word_less(logic [WordW-1:0] a, logic [WordW-1:0] b);
        logic [WordW-1:0] ra;
        logic [WordW-1:0] rb;
        for (int k = 0; k < WordW / 8; k++)
        begin
            ra[WordW-1-8*k -: 8] = a[8*k +: 8];
            rb[WordW-1-8*k -: 8] = b[8*k +: 8];
        end
        return ra < rb;
    endfunction

endpackage

// ===== hdl/word_frequency_sorted_counter.sv =====
// Word frequency sorted counter.
// A read walks the table twice (find smallest greater word, then count it);
// if no greater word is left, the count walk is skipped.
// Reset clears the control state and counts; the word memory holds no reset
// and entries above the fill count are never used in a comparison.
// Depends on wfsc_pkg.
module word_frequency_sorted_counter (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   op,
    input  logic [7:0]   ch,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [63:0]  word_chars_0_7,
    output logic [63:0]  word_chars_8_15,
    output logic [23:0]  word_chars_16_18,
    output logic [4:0]   word_len,
    output logic [10:0]  occurrences,
    output logic [1:0]   status,
    output logic         table_overflow
);

    localparam int AW = wfsc_pkg::AddrW;
    localparam int CW = wfsc_pkg::CountW;
    localparam int WW = wfsc_pkg::WordW;

    logic [WW-1:0] mem [wfsc_pkg::MaxWords];

    wfsc_pkg::state_t state_reg, state_next;
    logic [CW-1:0] total_reg, total_next;
    logic [WW-1:0] pend_reg, pend_next;
    logic [4:0]    plen_reg, plen_next;
    logic          ovf_reg, ovf_next;
    logic [WW-1:0] last_reg, last_next;
    logic          started_reg, started_next;
    logic [WW-1:0] best_reg, best_next;
    logic          found_reg, found_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [WW-1:0] rd_reg;
    logic          mem_we;

    logic          ov_reg, ov_next;
    logic [WW-1:0] ow_reg, ow_next;
    logic [4:0]    ol_reg, ol_next;
    logic [10:0]   oo_reg, oo_next;
    logic [1:0]    os_reg, os_next;

    logic accept, out_free, is_delim, less_rd_best, greater_last, eq_best;

    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (state_reg != wfsc_pkg::S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;
    assign is_delim = ch == wfsc_pkg::ChSpace || ch == wfsc_pkg::ChComma ||
                      ch == wfsc_pkg::ChDot || ch == wfsc_pkg::ChBang ||
                      ch == wfsc_pkg::ChQuery;

    // Comparator operands: the word just read against best or last
    assign less_rd_best = wfsc_pkg::word_less(rd_reg, best_reg);
    assign greater_last = !started_reg || wfsc_pkg::word_less(last_reg, rd_reg);
    assign eq_best      = rd_reg == best_reg;

    // Write pending word into the table, read at the walk index
    assign mem_we = accept && pend_reg != '0 && total_reg < CW'(wfsc_pkg::MaxWords) &&
                    ((op == wfsc_pkg::OP_TEXT && is_delim) || op == wfsc_pkg::OP_END);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[total_reg[AW-1:0]] <= pend_reg;
        end
        rd_reg <= mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= wfsc_pkg::S_IDLE;
            total_reg   <= '0;
            pend_reg    <= '0;
            plen_reg    <= '0;
            ovf_reg     <= 1'b0;
            last_reg    <= '0;
            started_reg <= 1'b0;
            found_reg   <= 1'b0;
            idx_reg     <= '0;
            occ_reg     <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            pend_reg    <= pend_next;
            plen_reg    <= plen_next;
            ovf_reg     <= ovf_next;
            last_reg    <= last_next;
            started_reg <= started_next;
            found_reg   <= found_next;
            idx_reg     <= idx_next;
            occ_reg     <= occ_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        ow_reg   <= ow_next;
        ol_reg   <= ol_next;
        oo_reg   <= oo_next;
        os_reg   <= os_next;
    end

    // Sequencer: byte handling, then the two table walks of a read
    always_comb
    begin
        state_next   = state_reg;
        total_next   = total_reg;
        pend_next    = pend_reg;
        plen_next    = plen_reg;
        ovf_next     = ovf_reg;
        last_next    = last_reg;
        started_next = started_reg;
        best_next    = best_reg;
        found_next   = found_reg;
        idx_next     = idx_reg;
        occ_next     = occ_reg;
        ov_next      = ov_reg && out_stall;
        ow_next      = ow_reg;
        ol_next      = ol_reg;
        oo_next      = oo_reg;
        os_next      = os_reg;

        unique case (state_reg)
            wfsc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    // flush pending word on a delimiter or end of text
                    if ((op == wfsc_pkg::OP_TEXT && is_delim) || op == wfsc_pkg::OP_END)
                    begin
                        if (plen_reg != '0)
                        begin
                            if (mem_we)
                            begin
                                total_next = total_reg + CW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            pend_next = '0;
                            plen_next = '0;
                        end
                    end
                    else if (op == wfsc_pkg::OP_TEXT && ch != 8'd0 &&
                             plen_reg < 5'(wfsc_pkg::MaxChars))
                    begin
                        pend_next[8*plen_reg +: 8] = ch;
                        plen_next = plen_reg + 5'd1;
                    end
                    if (op == wfsc_pkg::OP_END)
                    begin
                        started_next = 1'b0;
                        ov_next = 1'b1;
                        ow_next = '0;
                        ol_next = '0;
                        oo_next = 11'(total_next);
                        os_next = wfsc_pkg::ST_TOTAL;
                    end
                    else if (op == wfsc_pkg::OP_READ)
                    begin
                        idx_next   = '0;
                        found_next = 1'b0;
                        occ_next   = '0;
                        state_next = wfsc_pkg::S_FIND_RD;
                    end
                end
            end
            wfsc_pkg::S_FIND_RD:
            begin
                if (idx_reg == total_reg)
                begin
                    idx_next   = '0;
                    state_next = found_reg ? wfsc_pkg::S_CNT_RD : wfsc_pkg::S_DONE;
                end
                else
                begin
                    state_next = wfsc_pkg::S_FIND_CMP;
                end
            end
            wfsc_pkg::S_FIND_CMP:
            begin
                // keep the smallest word above the last one returned
                if (greater_last && (!found_reg || less_rd_best))
                begin
                    best_next  = rd_reg;
                    found_next = 1'b1;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = wfsc_pkg::S_FIND_RD;
            end
            wfsc_pkg::S_CNT_RD:
            begin
                state_next = (idx_reg == total_reg) ? wfsc_pkg::S_DONE
                                                    : wfsc_pkg::S_CNT_CMP;
            end
            wfsc_pkg::S_CNT_CMP:
            begin
                if (eq_best)
                begin
                    occ_next = occ_reg + CW'(1);
                end
                idx_next   = idx_reg + CW'(1);
                state_next = wfsc_pkg::S_CNT_RD;
            end
            wfsc_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    if (found_reg)
                    begin
                        last_next    = best_reg;
                        started_next = 1'b1;
                        ow_next      = best_reg;
                        ol_next      = '0;
                        for (int k = 0; k < wfsc_pkg::MaxChars; k++)
                        begin
                            if (best_reg[8*k +: 8] != 8'd0)
                            begin
                                ol_next = 5'(k + 1);
                            end
                        end
                        oo_next = 11'(occ_reg);
                        os_next = wfsc_pkg::ST_WORD;
                    end
                    else
                    begin
                        ow_next = '0;
                        ol_next = '0;
                        oo_next = '0;
                        os_next = wfsc_pkg::ST_EMPTY;
                    end
                    state_next = wfsc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wfsc_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid        = ov_reg;
    assign word_chars_0_7   = ow_reg[63:0];
    assign word_chars_8_15  = ow_reg[127:64];
    assign word_chars_16_18 = ow_reg[151:128];
    assign word_len         = ol_reg;
    assign occurrences      = oo_reg;
    assign status           = os_reg;
    assign table_overflow   = ovf_reg;

    // Table fill never exceeds its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(wfsc_pkg::MaxWords))
        else $error("word table count beyond depth");

    // Overflow flag never clears once set
    assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

    // No input is taken while a table walk is running
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != wfsc_pkg::S_IDLE) |-> in_stall)
        else $error("input accepted during walk");

    // Pending length matches pending characters
    assert property (@(posedge clk) disable iff (!rst_n)
        (plen_reg == 5'd0) |-> (pend_reg == '0))
        else $error("pending word not cleared");

endmodule
